### hdl/dtr_pkg.sv
package dtr_pkg;

   // table geometry
   localparam int NUM_STATES      = 64;
   localparam int EDGES_PER_STATE = 8;
   localparam int CLASS_BITS      = 32;

   // fixed field widths
   localparam int STATE_W     = 6;
   localparam int CHAR_W      = 8;
   localparam int SLOT_W      = 3;
   localparam int IN_MASK_W   = 32;
   localparam int ACC_MASK_W  = 64;
   localparam int CLASS_DEPTH = 256;
   localparam int EADDR_W     = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int CLR_W       = $clog2(CLASS_DEPTH);

   // request codes
   localparam logic [1:0] REQ_CLASS_WR = 2'd0;
   localparam logic [1:0] REQ_EDGE_WR  = 2'd1;
   localparam logic [1:0] REQ_CHAR     = 2'd2;
   localparam logic [1:0] REQ_EMPTY    = 2'd3;

   // configuration register indexes
   localparam logic REG_START_STATE = 1'b0;
   localparam logic REG_ACCEPT_MASK = 1'b1;

   typedef logic [CLASS_BITS-1:0] cls_type;

   typedef struct packed {
      logic               valid;
      logic [STATE_W-1:0] target;
      cls_type            mask;
   } edge_entry_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [CHAR_W-1:0]  char_code;
      cls_type            class_mask;
      logic [STATE_W-1:0] edge_state;
      logic [SLOT_W-1:0]  edge_slot;
      logic [STATE_W-1:0] edge_target;
      cls_type            edge_mask;
      logic               edge_valid;
      logic               edge_ok;
      logic               last;
   } queue_item_type;

   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

   // keep the low class bits of an input mask
   function automatic cls_type to_cls(input logic [IN_MASK_W-1:0] v);
      cls_type r;
      r = '0;
      for (int i = 0; i < CLASS_BITS && i < IN_MASK_W; i++) begin
         r[i] = v[i];
      end
      return r;
   endfunction

endpackage

### hdl/dtr_ram.sv
module dtr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/dtr_front.sv
module dtr_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_type,
   input  logic [dtr_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [dtr_pkg::IN_MASK_W-1:0]   req_class_mask,
   input  logic [dtr_pkg::STATE_W-1:0]     req_edge_state,
   input  logic [dtr_pkg::SLOT_W-1:0]      req_edge_slot,
   input  logic [dtr_pkg::STATE_W-1:0]     req_edge_target,
   input  logic [dtr_pkg::IN_MASK_W-1:0]   req_edge_mask,
   input  logic                            req_edge_valid,
   input  logic                            req_last,
   input  dtr_pkg::back_status_type        back_status,
   output dtr_pkg::queue_head_type         head
);
   import dtr_pkg::*;

   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   queue_item_type      q_ff [Q_DEPTH];
   logic [Q_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]       count_ff, count_in;
   queue_item_type      item;
   logic                push;
   logic                pop;

   // classify the incoming word
   always_comb begin
      item.op          = req_type;
      item.char_code   = req_char_code;
      item.class_mask  = to_cls(req_class_mask);
      item.edge_state  = req_edge_state;
      item.edge_slot   = req_edge_slot;
      item.edge_target = req_edge_target;
      item.edge_mask   = to_cls(req_edge_mask);
      item.edge_valid  = req_edge_valid;
      item.edge_ok     = (int'(req_edge_state) < NUM_STATES)
                      && (int'(req_edge_slot) < EDGES_PER_STATE)
                      && (int'(req_edge_target) < NUM_STATES);
      item.last        = req_last;
   end

   assign req_stall = (int'(count_ff) == Q_DEPTH) || back_status.clearing;
   assign push      = req_valid && !req_stall;
   assign pop       = back_status.pop;

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = q_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= Q_DEPTH)
      else $error("queue count beyond depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> int'(count_ff) < Q_DEPTH)
      else $error("word taken with the queue full");
`endif

endmodule

### hdl/dtr_back.sv
module dtr_back (
   input  logic                             clock,
   input  logic                             reset,
   input  dtr_pkg::queue_head_type          head,
   output dtr_pkg::back_status_type         back_status,
   input  logic [dtr_pkg::STATE_W-1:0]      start_state,
   input  logic [dtr_pkg::ACC_MASK_W-1:0]   accept_mask,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_accepted,
   output logic [dtr_pkg::STATE_W-1:0]      rsp_final_state
);
   import dtr_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CLR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [STATE_W-1:0] cur_ff, cur_in;
   logic               dead_ff, dead_in;
   logic               in_unit_ff, in_unit_in;
   logic [CHAR_W-1:0]  ch_ff, ch_in;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_accepted_ff, rsp_accepted_in;
   logic [STATE_W-1:0] rsp_final_state_ff, rsp_final_state_in;

   logic                       class_we;
   logic [CHAR_W-1:0]          class_waddr;
   cls_type                    class_wdata;
   logic [CHAR_W-1:0]          class_raddr;
   cls_type                    class_rd;
   logic [EDGES_PER_STATE-1:0] edge_we;
   logic [EADDR_W-1:0]         edge_waddr;
   edge_entry_type             edge_wdata;
   edge_entry_type             edge_rd [EDGES_PER_STATE];

   logic               pop;
   logic               out_free;
   logic [STATE_W-1:0] eff_state;
   logic               eff_dead;
   logic               found;
   logic [STATE_W-1:0] found_target;
   logic [STATE_W-1:0] nxt_state;
   logic               nxt_dead;

   // class table
   dtr_ram #(.WIDTH(CLASS_BITS), .DEPTH(CLASS_DEPTH)) u_class_ram (
      .clock   (clock),
      .wr_en   (class_we),
      .wr_addr (class_waddr),
      .wr_data (class_wdata),
      .rd_addr (class_raddr),
      .rd_data (class_rd)
   );

   // one edge memory per priority slot, one row per source state
   for (genvar k = 0; k < EDGES_PER_STATE; k++) begin : g_slot
      dtr_ram #(.WIDTH($bits(edge_entry_type)), .DEPTH(NUM_STATES)) u_edge_ram (
         .clock   (clock),
         .wr_en   (edge_we[k]),
         .wr_addr (edge_waddr),
         .wr_data (edge_wdata),
         .rd_addr (eff_state[EADDR_W-1:0]),
         .rd_data (edge_rd[k])
      );
   end

   // state at which the next byte is taken
   assign eff_state   = in_unit_ff ? cur_ff : start_state;
   assign eff_dead    = in_unit_ff ? dead_ff : 1'b0;
   assign class_raddr = (state_ff == ST_EVAL) ? ch_ff : head.item.char_code;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // first matching edge in slot order
   always_comb begin
      found        = 1'b0;
      found_target = '0;
      for (int k = EDGES_PER_STATE - 1; k >= 0; k--) begin
         if (edge_rd[k].valid && ((edge_rd[k].mask & class_rd) != '0)) begin
            found        = 1'b1;
            found_target = edge_rd[k].target;
         end
      end
      if (int'(eff_state) >= NUM_STATES) begin
         found = 1'b0;
      end
      if (eff_dead) begin
         nxt_state = eff_state;
         nxt_dead  = 1'b1;
      end else if (found) begin
         nxt_state = found_target;
         nxt_dead  = 1'b0;
      end else begin
         nxt_state = eff_state;
         nxt_dead  = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in           = state_ff;
      clr_cnt_in         = clr_cnt_ff;
      cur_in             = cur_ff;
      dead_in            = dead_ff;
      in_unit_in         = in_unit_ff;
      ch_in              = ch_ff;
      last_in            = last_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_accepted_in    = rsp_accepted_ff;
      rsp_final_state_in = rsp_final_state_ff;
      pop                = 1'b0;
      class_we           = 1'b0;
      class_waddr        = head.item.char_code;
      class_wdata        = head.item.class_mask;
      edge_we            = '0;
      edge_waddr         = head.item.edge_state[EADDR_W-1:0];
      edge_wdata.valid   = head.item.edge_valid;
      edge_wdata.target  = head.item.edge_target;
      edge_wdata.mask    = head.item.edge_mask;
      case (state_ff)
         ST_CLEAR: begin
            // sweep both tables to zero after reset
            class_we    = 1'b1;
            class_waddr = clr_cnt_ff;
            class_wdata = '0;
            edge_we     = '1;
            edge_waddr  = clr_cnt_ff[EADDR_W-1:0];
            edge_wdata  = '0;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == '1) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (head.valid) begin
               case (head.item.op)
                  REQ_CLASS_WR: begin
                     pop      = 1'b1;
                     class_we = 1'b1;
                  end
                  REQ_EDGE_WR: begin
                     pop = 1'b1;
                     for (int k = 0; k < EDGES_PER_STATE; k++) begin
                        if (head.item.edge_ok && int'(head.item.edge_slot) == k) begin
                           edge_we[k] = 1'b1;
                        end
                     end
                  end
                  REQ_CHAR: begin
                     pop      = 1'b1;
                     ch_in    = head.item.char_code;
                     last_in  = head.item.last;
                     state_in = ST_EVAL;
                  end
                  REQ_EMPTY: begin
                     if (out_free) begin
                        pop                = 1'b1;
                        in_unit_in         = 1'b0;
                        dead_in            = 1'b0;
                        cur_in             = start_state;
                        rsp_valid_in       = 1'b1;
                        rsp_accepted_in    = 1'b0;
                        rsp_final_state_in = start_state;
                     end
                  end
                  default: begin
                     pop = 1'b0;
                  end
               endcase
            end
         end
         ST_EVAL: begin
            // tables read last cycle, step the machine
            if (!last_ff || out_free) begin
               cur_in     = nxt_state;
               dead_in    = nxt_dead;
               in_unit_in = !last_ff;
               state_in   = ST_ISSUE;
               if (last_ff) begin
                  rsp_valid_in       = 1'b1;
                  rsp_accepted_in    = !nxt_dead && accept_mask[nxt_state];
                  rsp_final_state_in = nxt_state;
               end
            end
         end
         default: begin
            state_in = ST_ISSUE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         cur_ff       <= '0;
         dead_ff      <= 1'b0;
         in_unit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         cur_ff       <= cur_in;
         dead_ff      <= dead_in;
         in_unit_ff   <= in_unit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ch_ff              <= ch_in;
      last_ff            <= last_in;
      rsp_accepted_ff    <= rsp_accepted_in;
      rsp_final_state_ff <= rsp_final_state_in;
   end

   assign back_status.pop      = pop;
   assign back_status.clearing = (state_ff == ST_CLEAR);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_accepted         = rsp_accepted_ff;
   assign rsp_final_state      = rsp_final_state_ff;

`ifndef SYNTHESIS
   a_eval_after_issue: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |-> $past(state_ff) == ST_ISSUE || $past(state_ff) == ST_EVAL)
      else $error("evaluation without a preceding issue");
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !pop)
      else $error("word taken during clearing pass");
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EVAL || $past(state_ff) == ST_ISSUE)
      else $error("result raised outside issue or evaluation");
`endif

endmodule

### hdl/dfa_token_recognizer.sv
// result: a last byte goes via the queue, ST_ISSUE and ST_EVAL before rsp_valid,
//   an empty unit from ST_ISSUE; a byte is issued once the one ahead is evaluated
//   (edge row read waits on the next state); one table load per cycle, one empty
//   unit per cycle while the output is free; a 4-word queue decouples the input
// reset: synchronous, active high, then both tables cleared with req_stall high
module dfa_token_recognizer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_type,
   input  logic [dtr_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [dtr_pkg::IN_MASK_W-1:0]   req_class_mask,
   input  logic [dtr_pkg::STATE_W-1:0]     req_edge_state,
   input  logic [dtr_pkg::SLOT_W-1:0]      req_edge_slot,
   input  logic [dtr_pkg::STATE_W-1:0]     req_edge_target,
   input  logic [dtr_pkg::IN_MASK_W-1:0]   req_edge_mask,
   input  logic                            req_edge_valid,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_accepted,
   output logic [dtr_pkg::STATE_W-1:0]     rsp_final_state,
   input  logic                            csr_write_enable,
   input  logic                            csr_index,
   input  logic [dtr_pkg::ACC_MASK_W-1:0]  csr_write_data
);
   import dtr_pkg::*;

   logic [STATE_W-1:0]    start_state_ff;
   logic [ACC_MASK_W-1:0] accept_mask_ff;
   back_status_type       back_status;
   queue_head_type        head;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_state_ff <= '0;
         accept_mask_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_START_STATE: start_state_ff <= csr_write_data[STATE_W-1:0];
            REG_ACCEPT_MASK: accept_mask_ff <= csr_write_data;
            default: start_state_ff <= start_state_ff;
         endcase
      end
   end

   dtr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_char_code   (req_char_code),
      .req_class_mask  (req_class_mask),
      .req_edge_state  (req_edge_state),
      .req_edge_slot   (req_edge_slot),
      .req_edge_target (req_edge_target),
      .req_edge_mask   (req_edge_mask),
      .req_edge_valid  (req_edge_valid),
      .req_last        (req_last),
      .back_status     (back_status),
      .head            (head)
   );

   dtr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .back_status     (back_status),
      .start_state     (start_state_ff),
      .accept_mask     (accept_mask_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_final_state (rsp_final_state)
   );

endmodule
